// ----- design/lav_pkg.sv -----
`default_nettype none
package lav_pkg;

  localparam int unsigned FRAC_BITS = 16;  // fraction bits of every fixed-point value
  localparam int unsigned VW = 32;   // coordinate width
  localparam int unsigned UW = 18;   // unit component width
  localparam int unsigned MW = 32;   // magnitude width after normalising shift
  localparam int unsigned SW = 64;   // sum of squares width
  localparam int unsigned LW = 33;   // length width
  localparam int unsigned QW = 18;   // quotient magnitude width

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [UW-1:0] x;
    logic signed [UW-1:0] y;
    logic signed [UW-1:0] z;
  } uvec_t;

endpackage
`default_nettype wire

// ----- design/lav_norm.sv -----
`default_nettype none
// Pipelined normaliser: one vector per cycle while adv is high.
// Stage 0 takes magnitudes and the common shift, stage 1 squares,
// a restoring square root gives one result bit per stage, and a restoring
// divider gives one quotient bit per stage for all three lanes.
module lav_norm (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire lav_pkg::vec_t     vec_i,
  output lav_pkg::uvec_t         unit_o
);

  localparam int unsigned FRAC_BITS = lav_pkg::FRAC_BITS;
  localparam int unsigned MW = lav_pkg::MW;
  localparam int unsigned SW = lav_pkg::SW;
  localparam int unsigned LW = lav_pkg::LW;
  localparam int unsigned QW = lav_pkg::QW;
  localparam int unsigned RB = SW / 2;          // root bits
  localparam int unsigned NW = MW + FRAC_BITS + 1;  // dividend width

  // stage A: magnitudes and shift
  logic [MW:0]  mag_a_r [3];
  logic [2:0]   neg_a_r;
  logic [MW:0]  mag   [3];
  logic [MW:0]  mx;
  logic [5:0]   k;
  logic [MW:0]  shf [3];

  always_comb begin
    mag[0] = vec_i.x[MW-1] ? (MW+1)'(-{1'b1, vec_i.x}) : {1'b0, vec_i.x};
    mag[1] = vec_i.y[MW-1] ? (MW+1)'(-{1'b1, vec_i.y}) : {1'b0, vec_i.y};
    mag[2] = vec_i.z[MW-1] ? (MW+1)'(-{1'b1, vec_i.z}) : {1'b0, vec_i.z};
    mx = mag[0] | mag[1] | mag[2];
    k = '0;
    for (int b = 0; b <= 30; b++) begin
      if (mx[b]) k = 6'(30 - b);
    end
    // A largest magnitude of 2^31 is already in range and takes no shift.
    if (mx[MW-1]) k = '0;
    for (int i = 0; i < 3; i++) shf[i] = mag[i] << k;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) mag_a_r[i] <= shf[i];
      neg_a_r <= {vec_i.z[MW-1], vec_i.y[MW-1], vec_i.x[MW-1]};
    end
  end

  // stage B: sum of squares (k is 0 when the largest magnitude is zero, is 2^31 or has bit 30 set)
  logic [SW+1:0] sum_b_r;
  logic [MW:0]   mag_b_r [3];
  logic [2:0]    neg_b_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_b_r <= (SW+2)'(mag_a_r[0] * mag_a_r[0]) + (SW+2)'(mag_a_r[1] * mag_a_r[1])
               + (SW+2)'(mag_a_r[2] * mag_a_r[2]);
      for (int i = 0; i < 3; i++) mag_b_r[i] <= mag_a_r[i];
      neg_b_r <= neg_a_r;
    end
  end

  // square root stages: RR result bits, one per stage
  localparam int unsigned RR = RB + 1;
  logic [SW+1:0] rem_r  [RR+1];
  logic [LW-1:0] root_r [RR+1];
  logic [MW:0]   mag_s_r [RR+1][3];
  logic [2:0]    neg_s_r [RR+1];

  always_comb begin
    rem_r[0]  = sum_b_r;
    root_r[0] = '0;
    for (int i = 0; i < 3; i++) mag_s_r[0][i] = mag_b_r[i];
    neg_s_r[0] = neg_b_r;
  end

  genvar g;
  generate
    for (g = 0; g < RR; g++) begin : g_sqrt
      localparam int unsigned SH = 2 * (RR - 1 - g);
      logic [SW+3:0] trial;
      logic [SW+3:0] rem_nxt;
      logic [LW-1:0] root_nxt;
      always_comb begin
        trial = ({2'b0, rem_r[g]} >> SH);
        rem_nxt = {2'b0, rem_r[g]};
        root_nxt = root_r[g] << 1;
        if (trial >= (SW+4)'({root_r[g], 2'b01})) begin
          rem_nxt = {2'b0, rem_r[g]} - ((SW+4)'({root_r[g], 2'b01}) << SH);
          root_nxt = (root_r[g] << 1) | LW'(1);
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[g+1]  <= rem_nxt[SW+1:0];
          root_r[g+1] <= root_nxt;
          for (int i = 0; i < 3; i++) mag_s_r[g+1][i] <= mag_s_r[g][i];
          neg_s_r[g+1] <= neg_s_r[g];
        end
      end
    end
  endgenerate

  // divider stages: QW quotient bits for three lanes
  logic [NW-1:0] num_r [QW+1][3];
  logic [QW-1:0] quo_r [QW+1][3];
  logic [LW-1:0] len_r [QW+1];
  logic [2:0]    neg_d_r [QW+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_r[0][i] = (NW'(mag_s_r[RR][i]) << FRAC_BITS) + NW'(root_r[RR] >> 1);
      quo_r[0][i] = '0;
    end
    len_r[0] = root_r[RR];
    neg_d_r[0] = neg_s_r[RR];
  end

  generate
    for (g = 0; g < QW; g++) begin : g_div
      localparam int unsigned SH = QW - 1 - g;
      logic [NW-1:0] nn [3];
      logic [QW-1:0] qn [3];
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          nn[i] = num_r[g][i];
          qn[i] = quo_r[g][i] << 1;
          if (len_r[g] != '0 &&
              (num_r[g][i] >> SH) >= NW'(len_r[g])) begin
            nn[i] = num_r[g][i] - (NW'(len_r[g]) << SH);
            qn[i] = (quo_r[g][i] << 1) | QW'(1);
          end
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int i = 0; i < 3; i++) begin
            num_r[g+1][i] <= nn[i];
            quo_r[g+1][i] <= qn[i];
          end
          len_r[g+1] <= len_r[g];
          neg_d_r[g+1] <= neg_d_r[g];
        end
      end
    end
  endgenerate

  always_comb begin
    unit_o.x = neg_d_r[QW][0] ? -$signed(quo_r[QW][0]) : $signed(quo_r[QW][0]);
    unit_o.y = neg_d_r[QW][1] ? -$signed(quo_r[QW][1]) : $signed(quo_r[QW][1]);
    unit_o.z = neg_d_r[QW][2] ? -$signed(quo_r[QW][2]) : $signed(quo_r[QW][2]);
  end

endmodule
`default_nettype wire

// ----- design/lav_delay.sv -----
`default_nettype none
// Delay line of register stages advancing with the pipeline.
module lav_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 1
) (
  input  wire logic         clk,
  input  wire logic         adv,
  input  wire logic [W-1:0] d_i,
  output logic [W-1:0]      q_o
);
  logic [W-1:0] tap_r [D];
  always_ff @(posedge clk) begin
    if (adv) begin
      tap_r[0] <= d_i;
      for (int i = 1; i < D; i++) tap_r[i] <= tap_r[i-1];
    end
  end
  assign q_o = tap_r[D-1];
endmodule
`default_nettype wire

// ----- design/look_at_view_matrix_core.sv -----
`default_nettype none
// Pipeline: one difference stage, two normalisers of 53 stages and 3 output stages.
// Throughput: one item per cycle unless the output stalls; the chain of normaliser
// square root and divider stages sets the latency, each stage holding one item.
// A stall at the output freezes the whole pipeline; no item is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
module look_at_view_matrix_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_from_x,
  input  wire logic signed [31:0] in_from_y,
  input  wire logic signed [31:0] in_from_z,
  input  wire logic signed [31:0] in_to_x,
  input  wire logic signed [31:0] in_to_y,
  input  wire logic signed [31:0] in_to_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [17:0]      out_m00,
  output logic signed [17:0]      out_m01,
  output logic signed [17:0]      out_m02,
  output logic signed [17:0]      out_m04,
  output logic signed [17:0]      out_m05,
  output logic signed [17:0]      out_m06,
  output logic signed [17:0]      out_m08,
  output logic signed [17:0]      out_m09,
  output logic signed [17:0]      out_m10,
  output logic signed [31:0]      out_tx,
  output logic signed [31:0]      out_ty,
  output logic signed [31:0]      out_tz
);

  localparam int unsigned FRAC_BITS = lav_pkg::FRAC_BITS;
  localparam int unsigned UW = lav_pkg::UW;
  localparam int unsigned ND = 2 + (lav_pkg::SW / 2 + 1) + lav_pkg::QW;
  localparam int unsigned LAT = 1 + ND + ND + 3;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic adv;
  logic [LAT-1:0] vld_r;
  assign adv = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] red(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + 64'(HALF)) >> FRAC_BITS;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [17:0] clu(input logic signed [63:0] v);
    if (v > ONE) return UW'(ONE);
    if (v < -ONE) return UW'(-ONE);
    return v[17:0];
  endfunction

  // stage 1: differences
  lav_pkg::vec_t d_r, eye_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      d_r.x <= sat32(34'(in_to_x) - 34'(in_from_x));
      d_r.y <= sat32(34'(in_to_y) - 34'(in_from_y));
      d_r.z <= sat32(34'(in_to_z) - 34'(in_from_z));
      eye_r <= {in_from_x, in_from_y, in_from_z};
    end
  end

  lav_pkg::uvec_t f_u, r_u, f_d;
  lav_pkg::vec_t  c_v, eye_d;

  lav_norm u_fwd (
    .clk(clk), .adv(adv), .vec_i(d_r), .unit_o(f_u));

  assign c_v.x = 32'(f_u.y);
  assign c_v.y = 32'(-33'(f_u.x));
  assign c_v.z = '0;

  lav_norm u_rgt (
    .clk(clk), .adv(adv), .vec_i(c_v), .unit_o(r_u));

  lav_delay #(.W(3 * UW), .D(ND)) u_fdly (
    .clk(clk), .adv(adv), .d_i(f_u), .q_o(f_d));
  lav_delay #(.W(96), .D(2 * ND)) u_edly (
    .clk(clk), .adv(adv), .d_i(eye_r), .q_o(eye_d));

  // stage A: cross products and the right and forward dot products
  logic signed [63:0] ux_r, uy_r, uz_r, dr_r, df_r;
  lav_pkg::uvec_t r_a, f_a;
  lav_pkg::vec_t  e_a;
  always_ff @(posedge clk) begin
    if (adv) begin
      ux_r <= 64'(r_u.y) * 64'(f_d.z);
      uy_r <= -(64'(r_u.x) * 64'(f_d.z));
      uz_r <= 64'(r_u.x) * 64'(f_d.y) - 64'(r_u.y) * 64'(f_d.x);
      dr_r <= 64'(r_u.x) * 64'(eye_d.x) + 64'(r_u.y) * 64'(eye_d.y)
            + 64'(r_u.z) * 64'(eye_d.z);
      df_r <= 64'(f_d.x) * 64'(eye_d.x) + 64'(f_d.y) * 64'(eye_d.y)
            + 64'(f_d.z) * 64'(eye_d.z);
      r_a <= r_u; f_a <= f_d; e_a <= eye_d;
    end
  end

  // stage B: up vector
  lav_pkg::uvec_t u_b, r_b, f_b;
  lav_pkg::vec_t  e_b;
  logic signed [63:0] dr_b, df_b;
  always_ff @(posedge clk) begin
    if (adv) begin
      u_b.x <= clu(red(ux_r));
      u_b.y <= clu(red(uy_r));
      u_b.z <= clu(red(uz_r));
      r_b <= r_a; f_b <= f_a; e_b <= e_a; dr_b <= dr_r; df_b <= df_r;
    end
  end

  // stage C: outputs
  logic signed [63:0] du;
  assign du = 64'(u_b.x) * 64'(e_b.x) + 64'(u_b.y) * 64'(e_b.y)
            + 64'(u_b.z) * 64'(e_b.z);
  always_ff @(posedge clk) begin
    if (adv) begin
      out_m00 <= clu(64'(r_b.x)); out_m04 <= clu(64'(r_b.y)); out_m08 <= clu(64'(r_b.z));
      out_m01 <= u_b.x; out_m05 <= u_b.y; out_m09 <= u_b.z;
      out_m02 <= clu(-64'(f_b.x)); out_m06 <= clu(-64'(f_b.y)); out_m10 <= clu(-64'(f_b.z));
      out_tx <= sat32(34'(-red(dr_b)));
      out_ty <= sat32(34'(-red(du)));
      out_tz <= sat32(34'(red(df_b)));
    end
  end

  property p_hold;
    @(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> out_valid;
  endproperty
  a_hold: assert property (p_hold) else $error("result dropped while stalled");

  property p_rdy;
    @(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready;
  endproperty
  a_rdy: assert property (p_rdy) else $error("stalled with empty output");

  property p_stall;
    @(posedge clk) disable iff (!rst_n) !in_ready |=> $stable(vld_r);
  endproperty
  a_stall: assert property (p_stall) else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

// ----- tb/tb_look_at_view_matrix_core.sv -----
`timescale 1ns / 100ps
module tb_look_at_view_matrix_core;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;
  localparam int N_RANDOM = 1150;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic signed [31:0] fx, fy, fz, tox, toy, toz;
  } camera_t;

  typedef struct packed {
    logic signed [17:0] m00, m01, m02, m04, m05, m06, m08, m09, m10;
    logic signed [31:0] tx, ty, tz;
  } view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_from_x = '0, in_from_y = '0, in_from_z = '0;
  logic signed [31:0] in_to_x = '0, in_to_y = '0, in_to_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [17:0] out_m00, out_m01, out_m02, out_m04, out_m05, out_m06;
  logic signed [17:0] out_m08, out_m09, out_m10;
  logic signed [31:0] out_tx, out_ty, out_tz;

  view_t pending_views[$];
  int failures = 0;
  int cameras_sent = 0;
  int views_checked = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  always #4 clk = ~clk;

  look_at_view_matrix_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_from_x(in_from_x), .in_from_y(in_from_y), .in_from_z(in_from_z),
    .in_to_x(in_to_x), .in_to_y(in_to_y), .in_to_z(in_to_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m04(out_m04), .out_m05(out_m05), .out_m06(out_m06),
    .out_m08(out_m08), .out_m09(out_m09), .out_m10(out_m10),
    .out_tx(out_tx), .out_ty(out_ty), .out_tz(out_tz)
  );

  function automatic longint sat_q(longint v);
    if (v > S32MAX) return S32MAX;
    if (v < S32MIN) return S32MIN;
    return v;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Magnitude rounded half up before the shift, sign restored afterwards.
  function automatic longint q_shrink(longint v);
    longint unsigned m;
    m = (longint'(abs64(v)) + (64'd1 << (FRAC - 1))) >> FRAC;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_vector(input longint v[3], output longint o[3]);
    longint unsigned a[3];
    longint unsigned mx, sq, len, q;
    int sh;
    mx = 0;
    sq = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = abs64(v[i]);
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while ((mx << sh) < (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) begin
      a[i] <<= sh;
      sq += a[i] * a[i];
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << FRAC) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic view_t build_view(camera_t c);
    longint eye[3], dir[3], fwd[3], side[3], rgt[3], up[3];
    longint tgt[3];
    view_t v;
    eye = '{longint'(c.fx), longint'(c.fy), longint'(c.fz)};
    tgt = '{longint'(c.tox), longint'(c.toy), longint'(c.toz)};
    for (int i = 0; i < 3; i++) dir[i] = sat_q(tgt[i] - eye[i]);
    unit_vector(dir, fwd);
    side = '{fwd[1], -fwd[0], 0};
    unit_vector(side, rgt);
    up[0] = clamp_one(q_shrink(rgt[1] * fwd[2] - rgt[2] * fwd[1]));
    up[1] = clamp_one(q_shrink(rgt[2] * fwd[0] - rgt[0] * fwd[2]));
    up[2] = clamp_one(q_shrink(rgt[0] * fwd[1] - rgt[1] * fwd[0]));
    v.m00 = 18'(clamp_one(rgt[0]));
    v.m04 = 18'(clamp_one(rgt[1]));
    v.m08 = 18'(clamp_one(rgt[2]));
    v.m01 = 18'(up[0]);
    v.m05 = 18'(up[1]);
    v.m09 = 18'(up[2]);
    v.m02 = 18'(clamp_one(-fwd[0]));
    v.m06 = 18'(clamp_one(-fwd[1]));
    v.m10 = 18'(clamp_one(-fwd[2]));
    v.tx = 32'(sat_q(-q_shrink(rgt[0] * eye[0] + rgt[1] * eye[1] + rgt[2] * eye[2])));
    v.ty = 32'(sat_q(-q_shrink(up[0] * eye[0] + up[1] * eye[1] + up[2] * eye[2])));
    v.tz = 32'(sat_q(q_shrink(fwd[0] * eye[0] + fwd[1] * eye[1] + fwd[2] * eye[2])));
    return v;
  endfunction

  // Directed cameras; rows flagged with a typed result are checked against it too.
  typedef struct {
    camera_t cam;
    bit      typed;
    view_t   view;
  } row_t;

  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;
  localparam logic signed [17:0] U1 = 18'sd65536;
  localparam logic signed [17:0] UM1 = -18'sd65536;

  row_t rows[] = '{
    '{'{0, 0, 0, 0, 0, 0}, 1, '0},
    '{'{QMAX, QMIN, QMAX, QMAX, QMIN, QMAX}, 1, '0},
    '{'{0, 0, 0, 0, 0, 32'sh10000}, 1, '{0, 0, 0, 0, 0, 0, 0, 0, UM1, 0, 0, 0}},
    '{'{0, 0, 0, 0, 0, -32'sh10000}, 1, '{0, 0, 0, 0, 0, 0, 0, 0, U1, 0, 0, 0}},
    '{'{0, 0, 32'sh30000, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0, 0, 0, U1, 0, 0, -32'sh30000}},
    '{'{0, 0, 0, 32'sh10000, 0, 0}, 0, '0},
    '{'{0, 0, 0, 0, 32'sh10000, 0}, 0, '0},
    '{'{0, 0, 0, -32'sh10000, -32'sh10000, 0}, 0, '0},
    '{'{QMIN, QMIN, QMIN, QMAX, QMAX, QMAX}, 0, '0},
    '{'{QMAX, QMAX, QMAX, QMIN, QMIN, QMIN}, 0, '0},
    '{'{QMAX, 0, 0, QMIN, 0, 0}, 0, '0},
    '{'{QMIN, QMAX, QMIN, 0, 0, 0}, 0, '0},
    '{'{32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 0}, 0, '0},
    '{'{0, 0, 0, 1, 1, 1}, 0, '0},
    '{'{1, 0, 0, 0, 1, 0}, 0, '0},
    '{'{QMAX, QMAX, 0, 0, 0, QMIN}, 0, '0},
    '{'{-1, -1, -1, 32'sh5555, -32'sh5555, 32'sh2aaaa}, 0, '0},
    '{'{32'sh7fff0000, -32'sh7fff0000, 32'sh12345, 0, 0, 32'sh12345}, 0, '0}
  };

  task automatic send_camera(camera_t c);
    in_from_x <= c.fx;
    in_from_y <= c.fy;
    in_from_z <= c.fz;
    in_to_x <= c.tox;
    in_to_y <= c.toy;
    in_to_z <= c.toz;
    in_valid <= 1'b1;
    pending_views.push_back(build_view(c));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cameras_sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? QMAX : QMIN;
      1: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
      2: return $signed(32'($urandom_range(0, 32'h3ff))) - 32'sh200;
      default: return $urandom;
    endcase
  endfunction

  function automatic camera_t rand_camera();
    camera_t c;
    c = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    case ($urandom_range(0, 9))
      0: {c.tox, c.toy, c.toz} = {c.fx, c.fy, c.fz};
      1: {c.tox, c.toy} = {c.fx, c.fy};
      default: ;
    endcase
    return c;
  endfunction

  // Receiver stalls at random, with occasional clean stretches.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[8:7] == 2'b01) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk) begin
    view_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_m00, out_m01, out_m02, out_m04, out_m05, out_m06,
              out_m08, out_m09, out_m10, out_tx, out_ty, out_tz};
      if (pending_views.size() == 0) begin
        $error("unexpected view matrix transfer");
        failures++;
      end else begin
        want = pending_views.pop_front();
        views_checked++;
        if (got.m00 !== want.m00) begin $error("m00 exp %0d got %0d", want.m00, got.m00); failures++; end
        if (got.m01 !== want.m01) begin $error("m01 exp %0d got %0d", want.m01, got.m01); failures++; end
        if (got.m02 !== want.m02) begin $error("m02 exp %0d got %0d", want.m02, got.m02); failures++; end
        if (got.m04 !== want.m04) begin $error("m04 exp %0d got %0d", want.m04, got.m04); failures++; end
        if (got.m05 !== want.m05) begin $error("m05 exp %0d got %0d", want.m05, got.m05); failures++; end
        if (got.m06 !== want.m06) begin $error("m06 exp %0d got %0d", want.m06, got.m06); failures++; end
        if (got.m08 !== want.m08) begin $error("m08 exp %0d got %0d", want.m08, got.m08); failures++; end
        if (got.m09 !== want.m09) begin $error("m09 exp %0d got %0d", want.m09, got.m09); failures++; end
        if (got.m10 !== want.m10) begin $error("m10 exp %0d got %0d", want.m10, got.m10); failures++; end
        if (got.tx !== want.tx) begin $error("tx exp %0d got %0d", want.tx, got.tx); failures++; end
        if (got.ty !== want.ty) begin $error("ty exp %0d got %0d", want.ty, got.ty); failures++; end
        if (got.tz !== want.tz) begin $error("tz exp %0d got %0d", want.tz, got.tz); failures++; end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) begin
      if (rows[i].typed && build_view(rows[i].cam) !== rows[i].view) begin
        $error("predictor disagrees with typed result of directed row %0d", i);
        failures++;
      end
      send_camera(rows[i].cam);
      if ($urandom_range(0, 3) == 0) pause_sender();
    end
    in_valid <= 1'b0;
    for (int n = 0; n < N_RANDOM;) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) send_camera(rand_camera());
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d cameras, checked %0d view matrices", cameras_sent, views_checked);
    $display("Covered eye-on-target, views along z and saturating coordinates.");
    if (failures == 0 && pending_views.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/lav_pkg.sv
design/lav_norm.sv
design/lav_delay.sv
design/look_at_view_matrix_core.sv
tb/tb_look_at_view_matrix_core.sv
